// ===== rtl/bba_pkg.sv =====
// Shared types, status codes and the region layout function for the buddy block allocator.
// Used by bba_fifo_regs and buddy_block_allocator; depends on nothing else.
package bba_pkg;

    localparam int DEFAULT_NUM_PAGES  = 4096;
    localparam int DEFAULT_NUM_ORDERS = 11;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_ORD = 2'd3
    } status_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [3:0] sel;
    } fifo_cmd_t;

    function automatic int region_base(int k, int n_pages);
        int acc;
        acc = 0;
        for (int j = 0; j < k; j++)
        begin
            acc = acc + (n_pages >> j);
        end
        return acc;
    endfunction

endpackage

// ===== rtl/bba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module bba_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bba_fifo_regs.sv =====
// Per-order head, tail and fill count registers of the free-block queues.
// Depends on bba_pkg for the command struct and the region layout function.
module bba_fifo_regs #(
    parameter int NUM_PAGES  = bba_pkg::DEFAULT_NUM_PAGES,
    parameter int NUM_ORDERS = bba_pkg::DEFAULT_NUM_ORDERS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bba_pkg::fifo_cmd_t                 cmd,
    output logic [$clog2(2*NUM_PAGES)-1:0]     sel_head,
    output logic [$clog2(2*NUM_PAGES)-1:0]     sel_tail,
    output logic [$clog2(NUM_PAGES+1)-1:0]     sel_count,
    output logic [$clog2(NUM_PAGES+1)-1:0]     sel_cap
);

    localparam int AW  = $clog2(2*NUM_PAGES);
    localparam int EW  = AW + 1;
    localparam int CW  = $clog2(NUM_PAGES+1);
    localparam int OIW = $clog2(NUM_ORDERS);

    logic [AW-1:0] base_c [NUM_ORDERS];
    logic [EW-1:0] end_c  [NUM_ORDERS];
    logic [CW-1:0] cap_c  [NUM_ORDERS];

    logic [AW-1:0] head_reg  [NUM_ORDERS];
    logic [AW-1:0] tail_reg  [NUM_ORDERS];
    logic [CW-1:0] count_reg [NUM_ORDERS];

    logic [OIW-1:0] idx;
    logic [EW-1:0]  head_inc;
    logic [EW-1:0]  tail_inc;
    logic [AW-1:0]  head_next;
    logic [AW-1:0]  tail_next;

    for (genvar g = 0; g < NUM_ORDERS; g++)
    begin : g_region
        assign base_c[g] = AW'(bba_pkg::region_base(g, NUM_PAGES));
        assign end_c[g]  = EW'(bba_pkg::region_base(g + 1, NUM_PAGES));
        assign cap_c[g]  = CW'(NUM_PAGES >> g);
    end

    assign idx       = cmd.sel[OIW-1:0];
    assign sel_head  = head_reg[idx];
    assign sel_tail  = tail_reg[idx];
    assign sel_count = count_reg[idx];
    assign sel_cap   = cap_c[idx];

    assign head_inc  = EW'(head_reg[idx]) + EW'(1);
    assign tail_inc  = EW'(tail_reg[idx]) + EW'(1);
    assign head_next = (head_inc >= end_c[idx]) ? base_c[idx] : head_inc[AW-1:0];
    assign tail_next = (tail_inc >= end_c[idx]) ? base_c[idx] : tail_inc[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ORDERS; i++)
            begin
                head_reg[i]  <= base_c[i];
                tail_reg[i]  <= base_c[i];
                count_reg[i] <= '0;
            end
        end
        else if (cmd.push)
        begin
            tail_reg[idx]  <= tail_next;
            count_reg[idx] <= count_reg[idx] + CW'(1);
        end
        else if (cmd.pop)
        begin
            head_reg[idx]  <= head_next;
            count_reg[idx] <= count_reg[idx] - CW'(1);
        end
    end

`ifndef SYNTH
    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop in the same cycle");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (sel_count < sel_cap))
        else $error("push into a full queue");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (sel_count != '0))
        else $error("pop from an empty queue");
`endif

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// Buddy block allocator: one word in, one result word out, strictly one item at a time.
// Add: one store write per block.
// Allocate: the order scan, queue room check and splits go order by order, and the pop
// waits on the store read port before the splits.
// The next word is accepted in the cycle after the result register loads; a held result delays it.
// Reset clears the sequencer, output valid and all queue counts, and sets the queue pointers to their region bases.
module buddy_block_allocator #(
    parameter int NUM_PAGES  = bba_pkg::DEFAULT_NUM_PAGES,
    parameter int NUM_ORDERS = bba_pkg::DEFAULT_NUM_ORDERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [3:0]  order,
    input  logic [11:0] base_page,
    input  logic [12:0] block_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] granted_page,
    output logic [1:0]  status
);

    localparam int AW = $clog2(2*NUM_PAGES);
    localparam int CW = $clog2(NUM_PAGES+1);
    localparam int PW = $clog2(NUM_PAGES);
    localparam int KW = $clog2(NUM_ORDERS+1);
    localparam int SW = ((CW > 13) ? CW : 13) + 1;
    localparam int XW = 30;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_ADD_CHK  = 9'b000000010,
        S_ADD_PUSH = 9'b000000100,
        S_SCAN     = 9'b000001000,
        S_ROOM     = 9'b000010000,
        S_POP      = 9'b000100000,
        S_POP_WAIT = 9'b001000000,
        S_SPLIT    = 9'b010000000,
        S_FIN      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic        mode_reg, mode_next;
    logic [3:0]  ord_reg, ord_next;
    logic [11:0] base_reg, base_next;
    logic [12:0] cnt_reg, cnt_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] j_reg, j_next;
    logic [PW-1:0] page_reg, page_next;
    logic [11:0] res_page_reg, res_page_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        out_valid_reg, out_valid_next;
    logic [11:0] out_page_reg, out_page_next;
    logic [1:0]  out_status_reg, out_status_next;

    bba_pkg::fifo_cmd_t cmd;
    logic [KW-1:0] sel_idx;
    logic [AW-1:0] sel_head;
    logic [AW-1:0] sel_tail;
    logic [CW-1:0] sel_count;
    logic [CW-1:0] sel_cap;
    logic [PW-1:0] wdata;
    logic [PW-1:0] rdata;
    logic [KW-1:0] j_dec;
    logic [XW-1:0] add_end;
    logic          add_over;
    logic          add_full;

    bba_fifo_regs #(
        .NUM_PAGES  (NUM_PAGES),
        .NUM_ORDERS (NUM_ORDERS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sel_head  (sel_head),
        .sel_tail  (sel_tail),
        .sel_count (sel_count),
        .sel_cap   (sel_cap)
    );

    bba_ram #(
        .WIDTH (PW),
        .DEPTH (2*NUM_PAGES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (sel_tail),
        .wdata (wdata),
        .raddr (sel_head),
        .rdata (rdata)
    );

    assign j_dec    = j_reg - KW'(1);
    assign add_end  = XW'(base_reg) + (XW'(cnt_reg) << ord_reg);
    assign add_over = add_end > XW'(NUM_PAGES);
    assign add_full = (SW'(sel_count) + SW'(cnt_reg)) > SW'(sel_cap);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        ord_next        = ord_reg;
        base_next       = base_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        page_next       = page_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        sel_idx         = KW'(ord_reg);
        cmd.push        = 1'b0;
        cmd.pop         = 1'b0;
        wdata           = page_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next     = mode;
                    ord_next      = order;
                    base_next     = base_page;
                    cnt_next      = block_count;
                    k_next        = KW'(order);
                    res_page_next = '0;
                    if ({1'b0, order} >= 5'(NUM_ORDERS))
                    begin
                        res_status_next = bba_pkg::ST_BAD_ORD;
                        state_next      = S_FIN;
                    end
                    else if (mode)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_ADD_CHK;
                    end
                end
            end
            S_ADD_CHK:
            begin
                page_next = PW'(base_reg);
                if (add_over || add_full)
                begin
                    res_status_next = bba_pkg::ST_FULL;
                    state_next      = S_FIN;
                end
                else if (cnt_reg == '0)
                begin
                    res_status_next = bba_pkg::ST_OK;
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_ADD_PUSH;
                end
            end
            S_ADD_PUSH:
            begin
                cmd.push  = 1'b1;
                page_next = page_reg + (PW'(1) << ord_reg);
                cnt_next  = cnt_reg - 13'd1;
                if (cnt_reg == 13'd1)
                begin
                    res_status_next = bba_pkg::ST_OK;
                    state_next      = S_FIN;
                end
            end
            S_SCAN:
            begin
                sel_idx = k_reg;
                if (k_reg == KW'(NUM_ORDERS))
                begin
                    res_status_next = bba_pkg::ST_NO_FREE;
                    state_next      = S_FIN;
                end
                else if (sel_count != '0)
                begin
                    j_next     = KW'(ord_reg);
                    state_next = S_ROOM;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_ROOM:
            begin
                sel_idx = j_reg;
                if (j_reg == k_reg)
                begin
                    state_next = S_POP;
                end
                else if (sel_count >= sel_cap)
                begin
                    res_status_next = bba_pkg::ST_FULL;
                    state_next      = S_FIN;
                end
                else
                begin
                    j_next = j_reg + KW'(1);
                end
            end
            S_POP:
            begin
                sel_idx    = k_reg;
                cmd.pop    = 1'b1;
                state_next = S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                page_next  = rdata;
                j_next     = k_reg;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                sel_idx = j_dec;
                wdata   = page_reg + (PW'(1) << j_dec);
                if (j_reg == KW'(ord_reg))
                begin
                    res_page_next   = 12'(page_reg);
                    res_status_next = bba_pkg::ST_OK;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.push = 1'b1;
                    j_next   = j_dec;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        cmd.sel = 4'(sel_idx);
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        if ((state_reg == S_FIN) && (!out_valid_reg || !out_stall))
        begin
            out_valid_next  = 1'b1;
            out_page_next   = res_page_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        ord_reg        <= ord_next;
        base_reg       <= base_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        j_reg          <= j_next;
        page_reg       <= page_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign granted_page = out_page_reg;
    assign status       = out_status_reg;

`ifndef SYNTH
    a_add_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_PUSH) |-> !mode_reg)
        else $error("add push sequence entered for an allocate word");
    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not moved to the output register");
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != bba_pkg::ST_OK)) |-> (out_page_reg == '0))
        else $error("failed word carries a nonzero page");
`endif

endmodule
